FILE: src/kdpp_pkg.sv
// ============================================================================
// kdpp_pkg
// shared constants for the keyed decimal parameter parser: field widths,
// configuration register indexes, scan phase codes and character codes
// ============================================================================
package kdpp_pkg;

    // parameter defaults
    localparam int NAME_MAX_CHARS_DEF = 8;
    localparam int VALUE_BITS_DEF     = 32;

    // fixed field widths
    localparam int CHAR_W     = 8;
    localparam int NAME_LEN_W = 4;
    localparam int LIMIT_W    = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int POS_W      = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHARS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LENGTH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 4'd3;

    // scan phases
    localparam logic [1:0] PH_SEARCH     = 2'd0;
    localparam logic [1:0] PH_WAIT_VALUE = 2'd1;
    localparam logic [1:0] PH_VALUE      = 2'd2;
    localparam logic [1:0] PH_DONE       = 2'd3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

endpackage

FILE: src/keyed_decimal_param_parser_core.sv
// ============================================================================
// keyed_decimal_param_parser_core
// scans a command line one character per item, finds the configured name
// token and converts the token after it to a clamped signed integer
// ============================================================================
//
// usage
//   input channel  : i_valid / o_stall carry i_char_code and i_line_end; an
//                    item is taken at a rising edge with i_valid high and
//                    o_stall low. i_line_end marks the last character.
//   output channel : o_valid / i_stall carry o_param_value, o_name_found and
//                    o_value_taken; one result per line, none for other chars.
//   config port    : i_cfg_we writes i_cfg_data into register i_cfg_idx
//                    (0 name chars, 1 name length, 2 lower, 3 upper limit);
//                    written by the user only while no line result is pending; not enforced.
//   throughput     : one character per cycle while o_stall is low; the scan state
//                    update (compare plus times-ten accumulate) is combinational.
//   result path    : the line-end character is registered into the clamp stage
//                    record, then the clamped result into the output register.
//   reset          : synchronous active-low reset clears the scan state and
//                    held value and loads the register reset values.
//   stall          : a waiting result holds in the output register; one more
//                    finished line may wait in the clamp stage, after which
//                    o_stall rises until the output moves.
//
module keyed_decimal_param_parser_core #(
    parameter int NAME_MAX_CHARS = kdpp_pkg::NAME_MAX_CHARS_DEF,
    parameter int VALUE_BITS     = kdpp_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // character input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [kdpp_pkg::CHAR_W-1:0]       i_char_code,
    input  logic                              i_line_end,
    // result output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [kdpp_pkg::LIMIT_W-1:0] o_param_value,
    output logic                              o_name_found,
    output logic                              o_value_taken,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [kdpp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kdpp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import kdpp_pkg::*;

    localparam int NAME_W = 8 * NAME_MAX_CHARS;
    localparam int PROD_W = VALUE_BITS + 4;
    // clamp arithmetic width, wide enough for value and limits plus sign
    localparam int CW     = ((VALUE_BITS > LIMIT_W) ? VALUE_BITS : LIMIT_W) + 1;

    localparam logic [VALUE_BITS-1:0] MAG_CAP = VALUE_BITS'(1) << (VALUE_BITS - 1);

    // configuration registers
    logic [NAME_W-1:0]         r_name_chars;
    logic [NAME_LEN_W-1:0]     r_name_length;
    logic signed [LIMIT_W-1:0] r_lower_limit;
    logic signed [LIMIT_W-1:0] r_upper_limit;

    // scan state
    logic [1:0]            r_phase,  n_phase;
    logic                  r_inside, n_inside;
    logic [POS_W-1:0]      r_pos,    n_pos;
    logic                  r_pm,     n_pm;
    logic                  r_neg,    n_neg;
    logic                  r_digit,  n_digit;
    logic                  r_bad,    n_bad;
    logic [VALUE_BITS-1:0] r_mag,    n_mag;

    // finished line waiting for the clamp stage
    logic                  r_fin_valid;
    logic                  r_fin_found;
    logic                  r_fin_taken;
    logic                  r_fin_neg;
    logic [VALUE_BITS-1:0] r_fin_mag;

    // held value and output register
    logic signed [LIMIT_W-1:0] r_held;
    logic                      r_out_valid;
    logic signed [LIMIT_W-1:0] r_out_value;
    logic                      r_out_found;
    logic                      r_out_taken;

    logic in_acc;
    logic fin_adv;
    logic sep;
    logic [CHAR_W-1:0] want;
    logic [PROD_W-1:0] prod;
    logic [CHAR_W-1:0] digit_val;
    logic              line_taken;

    // clamp stage signals
    logic signed [CW-1:0] mag_ext;
    logic signed [CW-1:0] x_val;
    logic signed [CW-1:0] lo_ext;
    logic signed [CW-1:0] hi_ext;
    logic signed [CW-1:0] clamp_val;

    // token position before this character is counted
    function automatic logic [POS_W-1:0] tok_pos();
        return r_inside ? r_pos : '0;
    endfunction

    // one finished line may move on when the output register is free or leaving
    assign fin_adv = r_fin_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_fin_valid && !fin_adv;
    assign in_acc  = i_valid && !o_stall;

    assign sep = (i_char_code == CH_SPACE) || (i_char_code == CH_EQUAL);

    // expected name byte at the current token position
    always_comb begin
        want = '0;
        for (int k = 0; k < NAME_MAX_CHARS; k++) begin
            if (tok_pos() == POS_W'(k)) begin
                want = r_name_chars[8*k +: 8];
            end
        end
    end

    // times-ten accumulate for a digit, saturating at the magnitude cap
    assign digit_val = i_char_code - CH_ZERO;
    assign prod = (PROD_W'(r_mag) << 3) + (PROD_W'(r_mag) << 1)
                + PROD_W'(digit_val[3:0]);

    // scan next state
    always_comb begin
        logic [1:0]       ph;
        logic [POS_W-1:0] pos;
        logic             pm;
        ph        = r_phase;
        pos       = r_pos;
        pm        = r_pm;
        n_inside  = r_inside;
        n_neg     = r_neg;
        n_digit   = r_digit;
        n_bad     = r_bad;
        n_mag     = r_mag;
        if (r_phase == PH_SEARCH) begin
            if (!sep) begin
                if (!r_inside) begin
                    pm = 1'b1;
                end
                pos = tok_pos();
                // compare only inside the name, longer tokens never match
                if (({1'b0, pos} < (POS_W+1)'(NAME_MAX_CHARS)) && (pos < r_name_length)) begin
                    if (want != i_char_code) begin
                        pm = 1'b0;
                    end
                end else begin
                    pm = 1'b0;
                end
                if (pos < POS_MAX) begin
                    pos = pos + 1'b1;
                end
                n_inside = 1'b1;
            end
            if (n_inside && (sep || i_line_end)) begin
                n_inside = 1'b0;
                if (pm && (pos == r_name_length) && (r_name_length != '0)) begin
                    ph  = PH_WAIT_VALUE;
                    pos = '0;
                end
            end
        end else begin
            if ((ph == PH_WAIT_VALUE) && !sep) begin
                ph      = PH_VALUE;
                pos     = '0;
                n_neg   = 1'b0;
                n_digit = 1'b0;
                n_bad   = 1'b0;
                n_mag   = '0;
            end
            if (ph == PH_VALUE) begin
                if (!sep) begin
                    if (i_char_code inside {[CH_TAB:CH_CR]}) begin
                        // leading white space only
                        if (pos != '0) begin
                            n_bad = 1'b1;
                        end
                    end else if (i_char_code inside {CH_PLUS, CH_MINUS}) begin
                        if (pos == '0) begin
                            pos   = POS_W'(1);
                            n_neg = (i_char_code == CH_MINUS);
                        end else begin
                            n_bad = 1'b1;
                        end
                    end else if (i_char_code inside {[CH_ZERO:CH_NINE]}) begin
                        pos     = POS_W'(1);
                        n_digit = 1'b1;
                        if (prod > PROD_W'(MAG_CAP)) begin
                            n_mag = MAG_CAP;
                        end else begin
                            n_mag = prod[VALUE_BITS-1:0];
                        end
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                if (sep || i_line_end) begin
                    ph = PH_DONE;
                end
            end
        end
        n_phase = ph;
        n_pos   = pos;
        n_pm    = pm;
    end

    assign line_taken = (n_phase == PH_DONE) && n_digit && !n_bad;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_chars  <= '0;
            r_name_length <= NAME_LEN_W'(1);
            r_lower_limit <= {1'b1, {(LIMIT_W-1){1'b0}}};
            r_upper_limit <= {1'b0, {(LIMIT_W-1){1'b1}}};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NAME_CHARS:  r_name_chars  <= i_cfg_data[NAME_W-1:0];
                CFG_NAME_LENGTH: r_name_length <= i_cfg_data[NAME_LEN_W-1:0];
                CFG_LOWER_LIMIT: r_lower_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_UPPER_LIMIT: r_upper_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // scan state, cleared after every line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEARCH;
            r_inside <= 1'b0;
            r_pos    <= '0;
            r_pm     <= 1'b1;
            r_neg    <= 1'b0;
            r_digit  <= 1'b0;
            r_bad    <= 1'b0;
            r_mag    <= '0;
        end else if (in_acc) begin
            if (i_line_end) begin
                r_phase  <= PH_SEARCH;
                r_inside <= 1'b0;
                r_pos    <= '0;
                r_pm     <= 1'b1;
                r_neg    <= 1'b0;
                r_digit  <= 1'b0;
                r_bad    <= 1'b0;
                r_mag    <= '0;
            end else begin
                r_phase  <= n_phase;
                r_inside <= n_inside;
                r_pos    <= n_pos;
                r_pm     <= n_pm;
                r_neg    <= n_neg;
                r_digit  <= n_digit;
                r_bad    <= n_bad;
                r_mag    <= n_mag;
            end
        end
    end

    // finished line record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (in_acc && i_line_end) begin
            r_fin_valid <= 1'b1;
        end else if (fin_adv) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_line_end) begin
            r_fin_found <= (n_phase != PH_SEARCH);
            r_fin_taken <= line_taken;
            r_fin_neg   <= n_neg;
            r_fin_mag   <= n_mag;
        end
    end

    // signed value of the number (or the held value when none was taken), saturated to the value range, then clamped
    always_comb begin
        mag_ext = CW'(r_fin_mag);
        if (r_fin_taken) begin
            if (r_fin_neg) begin
                x_val = -mag_ext;
            end else if (mag_ext > CW'(MAG_CAP) - CW'(1)) begin
                x_val = CW'(MAG_CAP) - CW'(1);
            end else begin
                x_val = mag_ext;
            end
        end else begin
            x_val = CW'(r_held);
        end
        lo_ext = CW'(r_lower_limit);
        hi_ext = CW'(r_upper_limit);
        // crossed limits: below lower wins over above upper
        if (x_val < lo_ext) begin
            clamp_val = lo_ext;
        end else if (x_val > hi_ext) begin
            clamp_val = hi_ext;
        end else begin
            clamp_val = x_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (fin_adv) begin
            r_held <= clamp_val[LIMIT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_adv) begin
            r_out_value <= clamp_val[LIMIT_W-1:0];
            r_out_found <= r_fin_found;
            r_out_taken <= r_fin_taken;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_param_value = r_out_value;
    assign o_name_found  = r_out_found;
    assign o_value_taken = r_out_taken;

    // a value is only taken after the name was found
    a_taken_needs_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid |-> (!r_fin_taken || r_fin_found))
        else $error("value taken without name");

    // the clamp stage holds its line until it can move on
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !fin_adv) |=> r_fin_valid)
        else $error("finished line dropped");

    // tokens are tracked only while searching for the name
    a_inside_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SEARCH) |-> !r_inside)
        else $error("token flag set outside name search");

    // input backpressure only comes from a blocked finished line
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_fin_valid && r_out_valid && i_stall))
        else $error("input stalled without cause");

endmodule
